@@ design/rar_pkg.sv @@
// Package for rational_arith_reduce: opcode and status codes, and output field widths.
`timescale 1ns / 1ps
package rar_pkg;

	typedef logic [1:0] opcode_t;
	typedef logic [1:0] status_t;

	localparam opcode_t OP_ADD = 2'd0;
	localparam opcode_t OP_SUB = 2'd1;
	localparam opcode_t OP_MUL = 2'd2;
	localparam opcode_t OP_DIV = 2'd3;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_ZERO_DEN = 2'd1;
	localparam status_t ST_DIV_ZERO = 2'd2;

	localparam int NUM_OUT_BITS = 33;
	localparam int DEN_OUT_BITS = 31;

endpackage

@@ design/rational_arith_reduce.sv @@
// Rational add/subtract/multiply/divide with binary-GCD reduction on one shared subtractor.
// An error transaction goes straight to the output; otherwise the steps are multiply, combine, GCD,
// shift-back, numerator divide, denominator divide and output, with a zero numerator skipping from
// combine to output.
// One transaction at a time: req_ready rises with rsp_valid, held back while an earlier result still waits.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops rsp_valid.
`timescale 1ns / 1ps
module rational_arith_reduce #(
	parameter int OPERAND_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  logic [1:0]                           opcode,
	input  logic signed [OPERAND_BITS-1:0]       num_a,
	input  logic signed [OPERAND_BITS-1:0]       den_a,
	input  logic signed [OPERAND_BITS-1:0]       num_b,
	input  logic signed [OPERAND_BITS-1:0]       den_b,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output logic signed [rar_pkg::NUM_OUT_BITS-1:0] result_num,
	output logic [rar_pkg::DEN_OUT_BITS-1:0]     result_den,
	output logic [1:0]                           status
);

	localparam int OB = OPERAND_BITS;
	localparam int MW = 2 * OB;
	localparam int SW = MW + 1;
	localparam int CW = $clog2(MW);
	localparam int KW = $clog2(MW + 1);
	localparam int EW = (MW > rar_pkg::NUM_OUT_BITS) ? MW : rar_pkg::NUM_OUT_BITS;
	localparam logic [CW-1:0] DIV_LAST = CW'(MW - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_COMB  = 3'd2;
	localparam logic [2:0] S_GCD   = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_DIVN  = 3'd5;
	localparam logic [2:0] S_DIVD  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]               state_q;
	logic [1:0]               mcnt_q;
	logic                     rsp_valid_q;

	rar_pkg::opcode_t         op_q;
	logic [OB-1:0]            na_q, da_q, nb_q, db_q;
	logic                     na_neg_q, da_neg_q, nb_neg_q, db_neg_q;
	logic [MW-1:0]            p0_q, p1_q, p2_q;
	logic [MW-1:0]            a_q, b_q, g_q, dm_q, d_q, rem_q, nq_q, dq_q;
	logic [KW-1:0]            k_q;
	logic [CW-1:0]            cnt_q;
	logic                     neg_q;
	rar_pkg::status_t         st_q;
	logic signed [rar_pkg::NUM_OUT_BITS-1:0] res_num_q;
	logic [rar_pkg::DEN_OUT_BITS-1:0]        res_den_q;
	rar_pkg::status_t         res_st_q;

	// Decode input operands into sign and magnitude
	logic [OB-1:0] na_mag, da_mag, nb_mag, db_mag;
	assign na_mag = num_a[OB-1] ? (~num_a + OB'(1)) : num_a;
	assign da_mag = den_a[OB-1] ? (~den_a + OB'(1)) : den_a;
	assign nb_mag = num_b[OB-1] ? (~num_b + OB'(1)) : num_b;
	assign db_mag = den_b[OB-1] ? (~den_b + OB'(1)) : den_b;

	logic in_zero_den, in_div_zero;
	assign in_zero_den = (da_mag == '0) || (db_mag == '0);
	assign in_div_zero = (opcode == rar_pkg::OP_DIV) && (nb_mag == '0);

	// Shared multiplier: operand select by step
	logic [OB-1:0] mul_x, mul_y;
	logic [MW-1:0] mul_p;
	always_comb begin
		unique case (mcnt_q)
			2'd0: begin
				mul_x = na_q;
				mul_y = (op_q == rar_pkg::OP_MUL) ? nb_q : db_q;
			end
			2'd1: begin
				mul_x = da_q;
				mul_y = nb_q;
			end
			default: begin
				mul_x = da_q;
				mul_y = (op_q == rar_pkg::OP_DIV) ? nb_q : db_q;
			end
		endcase
	end
	assign mul_p = MW'(mul_x) * MW'(mul_y);

	// Product signs
	logic s0, s1, sden;
	assign s0   = na_neg_q ^ ((op_q == rar_pkg::OP_MUL) ? nb_neg_q : db_neg_q);
	assign s1   = da_neg_q ^ nb_neg_q ^ (op_q == rar_pkg::OP_SUB);
	assign sden = da_neg_q ^ ((op_q == rar_pkg::OP_DIV) ? nb_neg_q : db_neg_q);

	// Combine cross products into the unreduced numerator
	logic [MW-1:0] num_mag;
	logic          num_neg;
	always_comb begin
		if (op_q == rar_pkg::OP_ADD || op_q == rar_pkg::OP_SUB) begin
			if (s0 == s1) begin
				num_mag = p0_q + p1_q;
				num_neg = s0;
			end else if (p0_q >= p1_q) begin
				num_mag = p0_q - p1_q;
				num_neg = s0;
			end else begin
				num_mag = p1_q - p0_q;
				num_neg = s1;
			end
		end else begin
			num_mag = p0_q;
			num_neg = s0;
		end
	end

	// Shared subtractor for GCD steps and division trials
	logic [SW-1:0] sub_x, sub_y, sub_d;
	logic [SW-1:0] div_sh;
	assign div_sh = {rem_q, d_q[MW-1]};
	always_comb begin
		if (state_q == S_GCD) begin
			sub_x = {1'b0, a_q};
			sub_y = {1'b0, b_q};
		end else begin
			sub_x = div_sh;
			sub_y = {1'b0, g_q};
		end
	end
	assign sub_d = sub_x - sub_y;

	logic          div_bit;
	logic [MW-1:0] rem_nxt, d_nxt;
	assign div_bit = ~sub_d[SW-1];
	assign rem_nxt = div_bit ? sub_d[MW-1:0] : div_sh[MW-1:0];
	assign d_nxt   = {d_q[MW-2:0], div_bit};

	logic gcd_end;
	assign gcd_end = (a_q == '0) || (b_q == '0);

	// Final sign and field sizing
	logic [EW-1:0] nq_ext, dq_ext, nq_sgn;
	assign nq_ext = EW'(nq_q);
	assign dq_ext = EW'(dq_q);
	assign nq_sgn = neg_q ? (~nq_ext + EW'(1)) : nq_ext;

	logic out_free;
	assign out_free = !rsp_valid_q || rsp_ready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mcnt_q      <= 2'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mcnt_q  <= 2'd0;
						state_q <= (in_zero_den || in_div_zero) ? S_DONE : S_MUL;
					end
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 2'd1;
					if (mcnt_q == 2'd2) begin
						state_q <= S_COMB;
					end
				end
				S_COMB: begin
					state_q <= (num_mag == '0) ? S_DONE : S_GCD;
				end
				S_GCD: begin
					if (gcd_end) begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (k_q == '0) begin
						state_q <= S_DIVN;
					end
				end
				S_DIVN: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_q     <= opcode;
					na_q     <= na_mag;
					da_q     <= da_mag;
					nb_q     <= nb_mag;
					db_q     <= db_mag;
					na_neg_q <= num_a[OB-1];
					da_neg_q <= den_a[OB-1];
					nb_neg_q <= num_b[OB-1];
					db_neg_q <= den_b[OB-1];
					nq_q     <= '0;
					dq_q     <= '0;
					neg_q    <= 1'b0;
					if (in_zero_den) begin
						st_q <= rar_pkg::ST_ZERO_DEN;
					end else if (in_div_zero) begin
						st_q <= rar_pkg::ST_DIV_ZERO;
					end else begin
						st_q <= rar_pkg::ST_OK;
					end
				end
			end
			S_MUL: begin
				unique case (mcnt_q)
					2'd0:    p0_q <= mul_p;
					2'd1:    p1_q <= mul_p;
					default: p2_q <= mul_p;
				endcase
			end
			S_COMB: begin
				a_q   <= num_mag;
				b_q   <= p2_q;
				d_q   <= num_mag;
				dm_q  <= p2_q;
				k_q   <= '0;
				neg_q <= (num_mag != '0) && (num_neg ^ sden);
				nq_q  <= '0;
				dq_q  <= MW'(1);
			end
			S_GCD: begin
				// Binary GCD: strip common twos, halve evens, subtract odds
				priority if (gcd_end) begin
					g_q <= a_q | b_q;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + KW'(1);
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (!sub_d[SW-1]) begin
					a_q <= sub_d[MW:1];
				end else begin
					a_q <= b_q;
					b_q <= a_q;
				end
			end
			S_SHIFT: begin
				// Restore common twos one bit a cycle
				if (k_q != '0) begin
					g_q <= g_q << 1;
					k_q <= k_q - KW'(1);
				end
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_DIVN: begin
				if (cnt_q == DIV_LAST) begin
					nq_q  <= d_nxt;
					d_q   <= dm_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else begin
					d_q   <= d_nxt;
					rem_q <= rem_nxt;
					cnt_q <= cnt_q + CW'(1);
				end
			end
			S_DIVD: begin
				cnt_q <= cnt_q + CW'(1);
				d_q   <= d_nxt;
				rem_q <= rem_nxt;
				if (cnt_q == DIV_LAST) begin
					dq_q <= d_nxt;
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_num_q <= nq_sgn[rar_pkg::NUM_OUT_BITS-1:0];
					res_den_q <= dq_ext[rar_pkg::DEN_OUT_BITS-1:0];
					res_st_q  <= st_q;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign req_ready  = (state_q == S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign result_num = res_num_q;
	assign result_den = res_den_q;
	assign status     = res_st_q;

	// Error results carry zero in both parts
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != rar_pkg::ST_OK |-> result_num == '0 && result_den == '0)
		else $error("error result with nonzero payload");

	// Good results always have a nonzero denominator
	a_ok_den: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == rar_pkg::ST_OK |-> result_den != '0)
		else $error("ok result with zero denominator");

	// Division remainder stays below the divisor
	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVN || state_q == S_DIVD) |-> rem_q < g_q && g_q != '0)
		else $error("division remainder out of range");

	// GCD operands never both vanish
	a_gcd_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_GCD |-> (a_q | b_q) != '0)
		else $error("gcd operands both zero");

	// Accepting a transaction drops ready on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready held after accept");

endmodule
